>>> rtl/core/b64d_pkg.sv
// Shared types, constants and the character table of the base64 stream decoder.
`timescale 1ns / 1ps
package b64d_pkg;

    // Pad character that ends a short final group
    localparam logic [7:0] PAD_CHAR = 8'h3D;

    // Default depth of the group queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // One decoded group: up to three bytes and how many of them to release
    typedef struct packed {
        logic [23:0] word;   // byte 0 in the high bits
        logic [1:0]  count;  // results in this group, 1 to 3
        logic        fin;    // last result of the group ends the message
        logic        has;    // 0 for an end-only result
    } group_t;

    // Lenient character map: unmapped bytes and pad give zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] v;
        v = 6'd0;
        if (c >= 8'h41 && c <= 8'h5A) v = 6'(c - 8'h41);
        else if (c >= 8'h61 && c <= 8'h7A) v = 6'(c - 8'h61 + 8'd26);
        else if (c >= 8'h30 && c <= 8'h39) v = 6'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B || c == 8'h2D || c == 8'h2E) v = 6'd62;
        else if (c == 8'h2F || c == 8'h2C || c == 8'h5F) v = 6'd63;
        return v;
    endfunction

endpackage

>>> rtl/core/b64d_front.sv
// Front end: accepts characters, keeps the group state and forms decoded groups.
`timescale 1ns / 1ps
module b64d_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [7:0]        text_char,
    input  logic              end_of_text,
    input  logic              q_full,
    output logic              grp_valid,
    output b64d_pkg::group_t  grp
);

    logic [1:0]  pos_reg, pos_next;
    logic [17:0] acc_reg, acc_next;
    logic        tpad_reg, tpad_next;

    logic        accept;
    logic        is_pad;
    logic [23:0] full_word;
    logic [23:0] aligned;
    logic [1:0]  fin_count;
    logic        fin_has;

    assign accept    = push && !q_full;
    assign is_pad    = (text_char == b64d_pkg::PAD_CHAR);
    assign full_word = {acc_reg, b64d_pkg::sextet_of(text_char)};

    // Left-align the held sextets so byte 0 sits in the high bits
    always_comb
    begin
        case (pos_reg)
            2'd0:    aligned = {full_word[5:0], 18'd0};
            2'd1:    aligned = {full_word[11:0], 12'd0};
            2'd2:    aligned = {full_word[17:0], 6'd0};
            default: aligned = full_word;
        endcase
    end

    // Byte count of the final group; fin_has low means end-only result
    always_comb
    begin
        fin_has   = 1'b1;
        fin_count = 2'd1;
        case (pos_reg)
            2'd3:    fin_count = !is_pad ? 2'd3 : (tpad_reg ? 2'd1 : 2'd2);
            2'd2:    fin_count = is_pad ? 2'd1 : 2'd2;
            2'd1:    fin_count = 2'd1;
            default: fin_has   = 1'b0;
        endcase
    end

    // Group request towards the queue
    always_comb
    begin
        grp_valid = accept && (end_of_text || pos_reg == 2'd3);
        grp.word  = fin_has || !end_of_text ? aligned : 24'd0;
        grp.count = end_of_text ? fin_count : 2'd3;
        grp.fin   = end_of_text;
        grp.has   = end_of_text ? fin_has : 1'b1;
    end

    // Group state update
    always_comb
    begin
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        tpad_next = tpad_reg;
        if (accept)
        begin
            if (end_of_text || pos_reg == 2'd3)
            begin
                pos_next  = 2'd0;
                acc_next  = 18'd0;
                tpad_next = 1'b0;
            end
            else
            begin
                if (pos_reg == 2'd2)
                    tpad_next = is_pad;
                acc_next = full_word[17:0];
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 2'd0;
            acc_reg  <= 18'd0;
            tpad_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            acc_reg  <= acc_next;
            tpad_reg <= tpad_next;
        end
    end

endmodule

>>> rtl/core/b64d_queue.sv
// Short queue of decoded groups between the front and back ends.
`timescale 1ns / 1ps
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  b64d_pkg::group_t  wr_grp,
    input  logic              rd_en,
    output b64d_pkg::group_t  head,
    output logic              q_empty,
    output logic              q_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::group_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == CW'(DEPTH));
    assign head    = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 1'b1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_grp;
    end

endmodule

>>> rtl/core/b64d_back.sv
// Back end: walks the head group and releases its bytes one per request.
`timescale 1ns / 1ps
module b64d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  b64d_pkg::group_t  head,
    input  logic              q_empty,
    input  logic              pop,
    output logic              q_pop,
    output logic              empty,
    output logic [7:0]        data_byte,
    output logic              has_data,
    output logic              final_result
);

    logic [1:0] sub_reg, sub_next;
    logic       take;
    logic       last_of_grp;

    assign empty       = q_empty;
    assign take        = pop && !q_empty;
    assign last_of_grp = (sub_reg == head.count - 2'd1);
    assign q_pop       = take && last_of_grp;

    // Byte select within the head group
    always_comb
    begin
        case (sub_reg)
            2'd0:    data_byte = head.word[23:16];
            2'd1:    data_byte = head.word[15:8];
            default: data_byte = head.word[7:0];
        endcase
        has_data     = head.has;
        final_result = head.fin && last_of_grp;
    end

    always_comb
    begin
        sub_next = sub_reg;
        if (take)
            sub_next = last_of_grp ? 2'd0 : sub_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sub_reg <= 2'd0;
        else
            sub_reg <= sub_next;
    end

endmodule

>>> rtl/core/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front end, group queue, back end.
// A completed group is written into the queue; its bytes are read at the queue head.
// Throughput: one character per cycle unless full; results leave at one per cycle
// unless empty, one request per byte, set by the byte walker at the queue head.
// full rises only while the group queue holds QUEUE_DEPTH groups.
// Reset (rst_n low, asynchronous) empties the queue and clears the group state.
`timescale 1ns / 1ps
module base64_stream_decoder #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_char,
    input  logic       end_of_text,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] data_byte,
    output logic       has_data,
    output logic       final_result
);

    b64d_pkg::group_t grp;
    b64d_pkg::group_t head;
    logic             grp_valid;
    logic             q_full;
    logic             q_empty;
    logic             q_pop;

    assign full = q_full;

    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .text_char   (text_char),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .grp_valid   (grp_valid),
        .grp         (grp)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (grp_valid),
        .wr_grp  (grp),
        .rd_en   (q_pop),
        .head    (head),
        .q_empty (q_empty),
        .q_full  (q_full)
    );

    b64d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .q_pop        (q_pop),
        .empty        (empty),
        .data_byte    (data_byte),
        .has_data     (has_data),
        .final_result (final_result)
    );

endmodule
